// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion macros for the hatch motor limit controller checkers.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define HMLC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmlc assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define HMLC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmlc assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/hmlc_pkg.sv =====
// hmlc_pkg.sv
// Shared types, codes and constants of the hatch motor limit controller.
// No dependencies.
`default_nettype none

package hmlc_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int TIMEOUT_W   = 16;
    localparam int ERR_W       = 4;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;
    localparam logic [ERR_W-1:0]     MAX_ERR_RESET = 4'd3;
    localparam logic [ERR_W-1:0]     ERR_SAT       = 4'hF;
    localparam logic [TIMEOUT_W-1:0] ELAPSED_SAT   = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR = 2'd1;

    // command codes
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OPEN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MOVING   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              limit_open;
        logic              limit_closed;
    } t_in_item;

    typedef struct packed {
        logic                drive_up;
        logic                drive_down;
        logic [STATUS_W-1:0] status;
        logic                busy_res;
        logic [ERR_W-1:0]    errors_seen;
        logic                locked_out;
    } t_out_item;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] move_timeout_ticks;
        logic [ERR_W-1:0]     max_errors;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0]  status_code;
        logic [ERR_W-1:0]     error_tally;
        logic                 lockout;
        logic                 run_active;
        logic                 run_toward_open;
        logic [TIMEOUT_W-1:0] elapsed_ticks;
        logic                 motor_up_on;
        logic                 motor_down_on;
    } t_state;

    localparam t_state STATE_RESET = '{
        status_code:     ST_STOPPED,
        error_tally:     '0,
        lockout:         1'b0,
        run_active:      1'b0,
        run_toward_open: 1'b0,
        elapsed_ticks:   '0,
        motor_up_on:     1'b0,
        motor_down_on:   1'b0
    };

endpackage

`default_nettype wire

// ===== hw/rtl/hmlc_cfg.sv =====
// hmlc_cfg.sv
// Configuration registers: move timeout and error limit, plain write port.
// Depends on hmlc_pkg.
`default_nettype none

module hmlc_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hmlc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hmlc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output hmlc_pkg::t_cfg                        o_cfg
);
    import hmlc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_timeout_ticks <= TIMEOUT_RESET;
            r_cfg.max_errors         <= MAX_ERR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_cfg.move_timeout_ticks <= i_cfg_wdata[TIMEOUT_W-1:0];
                CFG_MAX_ERR: r_cfg.max_errors         <= i_cfg_wdata[ERR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/hmlc_step.sv =====
// hmlc_step.sv
// Next-state logic for one item: timed moves, manual drive, stop, error reset.
// Depends on hmlc_pkg.
`default_nettype none

module hmlc_step (
    input  wire hmlc_pkg::t_state   i_state,
    input  wire hmlc_pkg::t_in_item i_item,
    input  wire hmlc_pkg::t_cfg     i_cfg,
    output hmlc_pkg::t_state        o_state
);
    import hmlc_pkg::*;

    logic                 reached;
    logic [TIMEOUT_W-1:0] elapsed_inc;
    logic [ERR_W-1:0]     tally_inc;
    t_state               n;

    assign reached     = i_state.run_toward_open ? i_item.limit_open : i_item.limit_closed;
    assign elapsed_inc = (i_state.elapsed_ticks != ELAPSED_SAT) ?
                         i_state.elapsed_ticks + 16'd1 : i_state.elapsed_ticks;
    assign tally_inc   = (i_state.error_tally != ERR_SAT) ?
                         i_state.error_tally + 4'd1 : i_state.error_tally;

    always_comb begin
        n = i_state;
        if (i_state.run_active) begin
            if (reached) begin
                n.motor_up_on   = 1'b0;
                n.motor_down_on = 1'b0;
                n.run_active    = 1'b0;
                n.status_code   = i_state.run_toward_open ? ST_OPEN : ST_CLOSED;
                n.error_tally   = '0;
            end else if (i_item.mode == MODE_TICK) begin
                n.elapsed_ticks = elapsed_inc;
                if (elapsed_inc >= i_cfg.move_timeout_ticks) begin
                    n.motor_up_on   = 1'b0;
                    n.motor_down_on = 1'b0;
                    n.run_active    = 1'b0;
                    n.status_code   = ST_ERROR;
                    n.error_tally   = tally_inc;
                    if (tally_inc >= i_cfg.max_errors) begin
                        n.lockout     = 1'b1;
                        n.status_code = ST_DISABLED;
                    end
                end
            end
        end else begin
            case (i_item.mode)
                MODE_OPEN: begin
                    if (!i_state.lockout) begin
                        if (i_item.limit_open) begin
                            n.status_code = ST_OPEN;
                        end else begin
                            n.motor_up_on     = 1'b1;
                            n.motor_down_on   = 1'b0;
                            n.run_active      = 1'b1;
                            n.run_toward_open = 1'b1;
                            n.elapsed_ticks   = '0;
                        end
                    end
                end
                MODE_CLOSE: begin
                    if (!i_state.lockout) begin
                        if (i_item.limit_closed) begin
                            n.status_code = ST_CLOSED;
                        end else begin
                            n.motor_up_on     = 1'b0;
                            n.motor_down_on   = 1'b1;
                            n.run_active      = 1'b1;
                            n.run_toward_open = 1'b0;
                            n.elapsed_ticks   = '0;
                        end
                    end
                end
                MODE_UP, MODE_DOWN: begin
                    if (!i_state.lockout) begin
                        n.motor_up_on   = (i_item.mode == MODE_UP);
                        n.motor_down_on = (i_item.mode == MODE_DOWN);
                        n.status_code   = ST_MOVING;
                    end
                end
                MODE_STOP: begin
                    n.motor_up_on   = 1'b0;
                    n.motor_down_on = 1'b0;
                    if (i_state.status_code == ST_MOVING) begin
                        n.status_code = ST_STOPPED;
                    end
                end
                MODE_RESET: begin
                    n.error_tally = '0;
                    n.lockout     = 1'b0;
                    if (i_item.limit_closed) begin
                        n.status_code = ST_CLOSED;
                    end else if (i_item.limit_open) begin
                        n.status_code = ST_OPEN;
                    end else begin
                        n.status_code = ST_STOPPED;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_state = n;

endmodule

`default_nettype wire

// ===== hw/rtl/hatch_motor_limit_controller_core.sv =====
// hatch_motor_limit_controller_core.sv
// Top level: input register, next-state logic, controller state and result register.
// Depends on hmlc_pkg, hmlc_cfg, hmlc_step.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (t_in_item)
//   result    out        o_out_valid / i_out_stall  o_out_data (t_out_item)
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// One item per cycle sustained unless the result side stalls; each item passes through the
// input register, then the result register.
// Reset is synchronous and restores the controller state and register defaults.
// A stall on the result side holds the result register; the input register still takes
// one more item, after which o_in_stall rises until the result moves on.
`default_nettype none

module hatch_motor_limit_controller_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire hmlc_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output hmlc_pkg::t_out_item                   o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [hmlc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hmlc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import hmlc_pkg::*;

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_s1_valid;
    t_in_item  r_s1_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      out_free;
    logic      s1_adv;
    logic      in_xfer;

    hmlc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    hmlc_step u_step (
        .i_state (r_state),
        .i_item  (r_s1_data),
        .i_cfg   (cfg),
        .o_state (n_state)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= i_in_data;
        end
        if (s1_adv) begin
            r_out_data.drive_up    <= n_state.motor_up_on;
            r_out_data.drive_down  <= n_state.motor_down_on;
            r_out_data.status      <= n_state.status_code;
            r_out_data.busy_res    <= n_state.run_active;
            r_out_data.errors_seen <= n_state.error_tally;
            r_out_data.locked_out  <= n_state.lockout;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/hmlc_chk.sv =====
// hmlc_chk.sv
// Port-level checker for the hatch motor limit controller, bound to the top level.
// Depends on hmlc_pkg, assert_macros.svh, hatch_motor_limit_controller_core.
`default_nettype none

`include "assert_macros.svh"

module hmlc_chk (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_stall,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire hmlc_pkg::t_out_item i_out_data
);
    import hmlc_pkg::*;

    logic out_held;
    logic busy_seen;
    logic one_drive;
    logic lock_seen;
    logic lock_quiet;

    assign out_held   = i_out_valid && i_out_stall;
    assign busy_seen  = i_out_valid && i_out_data.busy_res;
    assign one_drive  = i_out_data.drive_up ^ i_out_data.drive_down;
    assign lock_seen  = i_out_valid && i_out_data.locked_out;
    assign lock_quiet = (i_out_data.status == ST_DISABLED) && !i_out_data.drive_up &&
                        !i_out_data.drive_down && !i_out_data.busy_res;

    // a held result keeps its value
    `HMLC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, i_out_valid && $stable(i_out_data))

    `HMLC_ASSERT_IMP(a_in_stall_cause, i_clk, i_rst_n, i_in_stall, out_held)

    `HMLC_ASSERT_IMP(a_busy_one_drive, i_clk, i_rst_n, busy_seen, one_drive)

    `HMLC_ASSERT_IMP(a_lock_quiet, i_clk, i_rst_n, lock_seen, lock_quiet)

endmodule

bind hatch_motor_limit_controller_core hmlc_chk u_hmlc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
